FILE: rtl/cfd_pkg.sv
// Package for the CRC-16/ARC checked frame deframer.
// Holds the parse phases, result kinds, register indexes, shared structs
// and the byte-wide CRC update. No dependencies.
`default_nettype none

package cfd_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned CRC_W = 16;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'hA001;
   localparam logic [CRC_W-1:0] CRC_INIT = 16'h0000;
   localparam logic [DATA_W-1:0] TIMEOUT_RESET = 8'd40;

   // Frame parse phases
   typedef enum logic [3:0] {
      PH_HDR0 = 4'd0,
      PH_HDR1 = 4'd1,
      PH_DIR  = 4'd2,
      PH_MOD  = 4'd3,
      PH_CMD  = 4'd4,
      PH_LEN  = 4'd5,
      PH_PAY  = 4'd6,
      PH_CRCL = 4'd7,
      PH_CRCH = 4'd8
   } phase_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_CRC_ERR = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   // Input event kinds
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Register indexes (byte address bits [3:2])
   typedef enum logic [1:0] {
      REG_HDR_FIRST  = 2'd0,
      REG_HDR_SECOND = 2'd1,
      REG_DIR_CODE   = 2'd2,
      REG_TIMEOUT    = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [DATA_W-1:0] header_first;
      logic [DATA_W-1:0] header_second;
      logic [DATA_W-1:0] direction_code;
      logic [DATA_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] data_byte;
      logic [DATA_W-1:0] module_code;
      logic [DATA_W-1:0] command_code;
      logic [DATA_W-1:0] payload_length;
      logic [CRC_W-1:0]  received_crc;
      logic              frame_end;
   } result_type;

   // One byte of reflected CRC-16/ARC, bit by bit
   function automatic logic [CRC_W-1:0] crc16_arc_byte(
      input logic [CRC_W-1:0]  crc,
      input logic [DATA_W-1:0] b
   );
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
      for (int i = 0; i < DATA_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cfd_req_if.sv
// Input channel of the deframer: one received byte or one timer tick a beat.
// Depends on nothing.
`default_nettype none

interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/cfd_rsp_if.sv
// Result channel of the deframer: payload bytes and frame status beats.
// Depends on nothing.
`default_nettype none

interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  module_code;
   logic [7:0]  command_code;
   logic [7:0]  payload_length;
   logic [15:0] received_crc;
   logic        frame_end;

   modport source (output valid, output kind, output data_byte, output module_code,
                   output command_code, output payload_length, output received_crc,
                   output frame_end, input ready);
   modport sink   (input valid, input kind, input data_byte, input module_code,
                   input command_code, input payload_length, input received_crc,
                   input frame_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/cfd_csr.sv
// Configuration registers of the deframer behind an APB-style port.
// Depends on cfd_pkg.
`default_nettype none

module cfd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cfd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cfd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output cfd_pkg::cfg_type                    cfg
);
   import cfd_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_HDR_FIRST:  cfg_in.header_first   = pwdata[DATA_W-1:0];
            REG_HDR_SECOND: cfg_in.header_second  = pwdata[DATA_W-1:0];
            REG_DIR_CODE:   cfg_in.direction_code = pwdata[DATA_W-1:0];
            REG_TIMEOUT:    cfg_in.timeout_ticks  = pwdata[DATA_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first   <= '0;
         cfg_ff.header_second  <= '0;
         cfg_ff.direction_code <= '0;
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_HDR_FIRST:  prdata[DATA_W-1:0] = cfg_ff.header_first;
         REG_HDR_SECOND: prdata[DATA_W-1:0] = cfg_ff.header_second;
         REG_DIR_CODE:   prdata[DATA_W-1:0] = cfg_ff.direction_code;
         REG_TIMEOUT:    prdata[DATA_W-1:0] = cfg_ff.timeout_ticks;
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/cfd_parser.sv
// Frame parser: phase machine, frame fields, tick counter and CRC-16/ARC.
// Builds the result of each accepted beat in one pass. Depends on cfd_pkg.
`default_nettype none

module cfd_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfd_pkg::cfg_type           cfg,
   input  wire logic                       fire,
   input  wire logic                       mode,
   input  wire logic [cfd_pkg::DATA_W-1:0] rx_byte,
   output logic                            emit,
   output cfd_pkg::result_type             result
);
   import cfd_pkg::*;

   phase_type         phase_ff, phase_in, phase_eff;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [DATA_W-1:0] module_ff, module_in;
   logic [DATA_W-1:0] command_ff, command_in;
   logic [DATA_W-1:0] length_ff, length_in;
   logic [DATA_W-1:0] remain_ff, remain_in;
   logic [DATA_W-1:0] crc_low_ff, crc_low_in;
   logic [DATA_W-1:0] wait_ff, wait_in;
   logic [DATA_W-1:0] wait_inc;
   logic              timed_out;
   logic [CRC_W-1:0]  rx_crc;

   // Fold unused phase codes into hunting
   assign phase_eff = (phase_ff <= PH_CRCH) ? phase_ff : PH_HDR0;
   assign wait_inc  = wait_ff + 8'd1;
   assign timed_out = (wait_inc >= cfg.timeout_ticks);
   assign rx_crc    = {rx_byte, crc_low_ff};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (mode == MODE_TICK) begin
            if (phase_eff != PH_HDR0 && timed_out) begin
               phase_in = PH_HDR0;
            end
         end else begin
            case (phase_eff)
               PH_HDR0: phase_in = (rx_byte == cfg.header_first) ? PH_HDR1 : PH_HDR0;
               PH_HDR1: phase_in = (rx_byte == cfg.header_second) ? PH_DIR : PH_HDR0;
               PH_DIR:  phase_in = (rx_byte == cfg.direction_code) ? PH_MOD : PH_HDR0;
               PH_MOD:  phase_in = PH_CMD;
               PH_CMD:  phase_in = PH_LEN;
               PH_LEN:  phase_in = (rx_byte == '0) ? PH_CRCL : PH_PAY;
               PH_PAY:  phase_in = (remain_ff == 8'd1) ? PH_CRCL : PH_PAY;
               PH_CRCL: phase_in = PH_CRCH;
               PH_CRCH: phase_in = PH_HDR0;
               default: phase_in = PH_HDR0;
            endcase
         end
      end
   end

   // Frame fields, counters and the result beat
   always_comb begin
      crc_in     = crc_ff;
      module_in  = module_ff;
      command_in = command_ff;
      length_in  = length_ff;
      remain_in  = remain_ff;
      crc_low_in = crc_low_ff;
      wait_in    = wait_ff;
      emit       = 1'b0;
      result.kind           = KIND_PAYLOAD;
      result.data_byte      = '0;
      result.module_code    = module_ff;
      result.command_code   = command_ff;
      result.payload_length = length_ff;
      result.received_crc   = '0;
      result.frame_end      = 1'b0;
      if (fire) begin
         if (mode == MODE_TICK) begin
            // Count ticks only while a frame is open
            if (phase_eff != PH_HDR0) begin
               wait_in = wait_inc;
               if (timed_out) begin
                  emit             = 1'b1;
                  result.kind      = KIND_TIMEOUT;
                  result.frame_end = 1'b1;
                  wait_in          = '0;
                  remain_in        = '0;
               end
            end
         end else begin
            case (phase_eff)
               PH_HDR0: begin
                  if (rx_byte == cfg.header_first) begin
                     module_in  = '0;
                     command_in = '0;
                     length_in  = '0;
                     crc_in     = CRC_INIT;
                     crc_low_in = '0;
                     wait_in    = '0;
                  end
               end
               PH_HDR1: begin
                  if (rx_byte != cfg.header_second) begin
                     wait_in   = '0;
                     remain_in = '0;
                  end
               end
               PH_DIR: begin
                  if (rx_byte != cfg.direction_code) begin
                     wait_in   = '0;
                     remain_in = '0;
                  end
               end
               PH_MOD:  module_in  = rx_byte;
               PH_CMD:  command_in = rx_byte;
               PH_LEN: begin
                  length_in = rx_byte;
                  remain_in = rx_byte;
                  crc_in    = CRC_INIT;
               end
               PH_PAY: begin
                  crc_in           = crc16_arc_byte(crc_ff, rx_byte);
                  remain_in        = remain_ff - 8'd1;
                  emit             = 1'b1;
                  result.data_byte = rx_byte;
               end
               PH_CRCL: crc_low_in = rx_byte;
               PH_CRCH: begin
                  emit                = 1'b1;
                  result.kind         = (rx_crc == crc_ff) ? KIND_GOOD : KIND_CRC_ERR;
                  result.received_crc = rx_crc;
                  result.frame_end    = 1'b1;
                  wait_in             = '0;
                  remain_in           = '0;
               end
               default: begin
                  wait_in = wait_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         crc_ff     <= CRC_INIT;
         module_ff  <= '0;
         command_ff <= '0;
         length_ff  <= '0;
         remain_ff  <= '0;
         crc_low_ff <= '0;
         wait_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         crc_ff     <= crc_in;
         module_ff  <= module_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         remain_ff  <= remain_in;
         crc_low_ff <= crc_low_in;
         wait_ff    <= wait_in;
      end
   end

   // Hunting always starts from a clean counter set
   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HDR0 |-> (wait_ff == '0 && remain_ff == '0))
      else $error("counters not cleared while hunting");

   // A payload phase always has bytes left to take
   a_pay_remain: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAY |-> remain_ff != '0)
      else $error("payload phase with no bytes remaining");

   // Status beats close a frame, payload beats do not
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      emit |-> (result.frame_end == (result.kind != KIND_PAYLOAD)))
      else $error("frame_end disagrees with kind");

   // A CRC check beat returns to hunting on the next cycle
   a_crc_hunt: assert property (@(posedge clock) disable iff (reset)
      (emit && (result.kind == KIND_GOOD || result.kind == KIND_CRC_ERR))
      |=> phase_ff == PH_HDR0)
      else $error("no return to hunting after CRC check");

endmodule

`default_nettype wire

FILE: rtl/cfd_out_stage.sv
// Result register of the deframer; holds one beat until the sink takes it.
// Depends on cfd_pkg and cfd_rsp_if.
`default_nettype none

module cfd_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire cfd_pkg::result_type  result,
   output logic                      take,
   cfd_rsp_if.source                 rsp_bus
);
   import cfd_pkg::*;

   logic       valid_ff;
   result_type res_ff;

   // Free when empty or when the held beat leaves this cycle
   assign take = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (take && load) begin
         res_ff <= result;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.kind           = res_ff.kind;
   assign rsp_bus.data_byte      = res_ff.data_byte;
   assign rsp_bus.module_code    = res_ff.module_code;
   assign rsp_bus.command_code   = res_ff.command_code;
   assign rsp_bus.payload_length = res_ff.payload_length;
   assign rsp_bus.received_crc   = res_ff.received_crc;
   assign rsp_bus.frame_end      = res_ff.frame_end;

endmodule

`default_nettype wire

FILE: rtl/crc16_checked_frame_deframer.sv
// Top level of the header/length/CRC-16/ARC frame deframer.
// Depends on cfd_pkg, cfd_req_if, cfd_rsp_if, cfd_csr, cfd_parser, cfd_out_stage.
//
//   channel   | dir | handshake            | beat
//   ----------+-----+----------------------+--------------------------------------
//   req_bus   | in  | valid/ready          | mode, rx_byte (byte or timer tick)
//   rsp_bus   | out | valid/ready          | kind, data, frame fields, crc, end
//   csr (APB) | in  | psel/penable, pready | 8-bit registers at byte addr 4*i
//
// One beat per cycle: each accepted beat is parsed in the same cycle and its
// result, if any, lands in the result register at that edge.
// The limit is the single result register: a beat is taken whenever that
// register is empty or is being emptied in the same cycle.
// Synchronous active-high reset returns the parser to hunting, clears all
// frame state and loads register defaults; no clearing pass is needed.
`default_nettype none

module crc16_checked_frame_deframer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cfd_req_if.sink                             req_bus,
   cfd_rsp_if.source                           rsp_bus,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cfd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cfd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import cfd_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       emit;
   logic       take;
   logic       fire;

   // Accept a beat whenever the result register can take its outcome
   assign req_bus.ready = take;
   assign fire          = req_bus.valid && take;

   cfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .fire    (fire),
      .mode    (req_bus.mode),
      .rx_byte (req_bus.rx_byte),
      .emit    (emit),
      .result  (result)
   );

   cfd_out_stage u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (fire && emit),
      .result  (result),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
